// File: design/kbh_pkg.sv
package kbh_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 32;
    localparam int BUCKET_W    = 16;
    localparam int GROUP_BYTES = 4;
    localparam int PEND_W      = (GROUP_BYTES - 1) * BYTE_W;
    localparam int PCNT_W      = 2;

    // bucket count after reset
    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 16'd256;

    // hash queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // one dividend bit per step over the hash word
    localparam int STEP_W      = 5;

    // input word
    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              last_byte;
        logic              no_byte;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [HASH_W-1:0]   hash_word;
    } out_word_t;

    // hash queue status
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// File: design/kbh_front.sv
module kbh_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  kbh_pkg::in_word_t          in_word,
    input  kbh_pkg::qstat_t            q_status,
    output logic                       q_wr_en,
    output logic [kbh_pkg::HASH_W-1:0] q_wr_data
);

    logic [kbh_pkg::HASH_W-1:0] acc_reg, acc_next, acc_f;
    logic [kbh_pkg::PEND_W-1:0] pend_reg, pend_next, pend_f;
    logic [kbh_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next, pcnt_f;
    logic                       folded_reg, folded_next, folded_f;
    logic [kbh_pkg::HASH_W-1:0] tail_group;
    logic [kbh_pkg::HASH_W-1:0] hash_f;
    logic                       accept;

    // a word is taken whenever the hash queue has room
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // fold the incoming byte into the pending group or the accumulator
    always_comb
    begin
        acc_f    = acc_reg;
        pend_f   = pend_reg;
        pcnt_f   = pcnt_reg;
        folded_f = folded_reg;
        if (!in_word.no_byte)
        begin
            if (pcnt_reg == kbh_pkg::PCNT_W'(kbh_pkg::GROUP_BYTES - 1))
            begin
                acc_f    = (acc_reg >> 1) ^ {pend_reg, in_word.key_byte};
                folded_f = 1'b1;
                pend_f   = '0;
                pcnt_f   = '0;
            end
            else
            begin
                pend_f = {pend_reg[kbh_pkg::PEND_W-kbh_pkg::BYTE_W-1:0], in_word.key_byte};
                pcnt_f = pcnt_reg + 1'b1;
            end
        end
    end

    // trailing partial group, left-aligned
    always_comb
    begin
        unique case (pcnt_f)
            2'd1:    tail_group = {pend_f[7:0], 24'h0};
            2'd2:    tail_group = {pend_f[15:0], 16'h0};
            2'd3:    tail_group = {pend_f, 8'h0};
            default: tail_group = '0;
        endcase
    end

    // final hash of the key
    always_comb
    begin
        priority if (!folded_f)
            hash_f = {{(kbh_pkg::HASH_W - kbh_pkg::PEND_W){1'b0}}, pend_f};
        else if (pcnt_f != '0)
            hash_f = (acc_f >> 1) ^ tail_group;
        else
            hash_f = acc_f;
    end

    assign q_wr_en   = accept && in_word.last_byte;
    assign q_wr_data = hash_f;

    // key state update, cleared after the last byte
    always_comb
    begin
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        folded_next = folded_reg;
        if (accept)
        begin
            if (in_word.last_byte)
            begin
                acc_next    = '0;
                pend_next   = '0;
                pcnt_next   = '0;
                folded_next = 1'b0;
            end
            else
            begin
                acc_next    = acc_f;
                pend_next   = pend_f;
                pcnt_next   = pcnt_f;
                folded_next = folded_f;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pend_reg   <= '0;
            pcnt_reg   <= '0;
            folded_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            pcnt_reg   <= pcnt_next;
            folded_reg <= folded_next;
        end
    end

    // key state is clear after a key ends
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_word.last_byte) |=>
            (pcnt_reg == '0 && !folded_reg && acc_reg == '0 && pend_reg == '0))
        else $error("key state not cleared after last byte");

    // nothing folded means the accumulator is still zero
    a_acc_zero_unfolded: assert property (@(posedge clk) disable iff (!rst_n)
        !folded_reg |-> (acc_reg == '0))
        else $error("accumulator set before first fold");

endmodule

// File: design/kbh_queue.sv
module kbh_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [kbh_pkg::HASH_W-1:0] wr_data,
    input  logic                       rd_en,
    output logic [kbh_pkg::HASH_W-1:0] rd_data,
    output kbh_pkg::qstat_t            status
);

    logic [kbh_pkg::HASH_W-1:0] slot_reg [kbh_pkg::QUEUE_DEPTH];
    logic [kbh_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [kbh_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [kbh_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                       do_wr, do_rd;

    assign status.full  = (cnt_reg == kbh_pkg::QCNT_W'(kbh_pkg::QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = slot_reg[rptr_reg];

    // pointer and fill count
    always_comb
    begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hash slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !status.full)
        else $error("hash queue written while full");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= kbh_pkg::QCNT_W'(kbh_pkg::QUEUE_DEPTH))
        else $error("hash queue count out of range");

endmodule

// File: design/kbh_back.sv
module kbh_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [kbh_pkg::BUCKET_W-1:0] cfg_wr_data,
    input  kbh_pkg::qstat_t              q_status,
    input  logic [kbh_pkg::HASH_W-1:0]   q_rd_data,
    output logic                         q_rd_en,
    output logic                         empty,
    input  logic                         pop,
    output kbh_pkg::out_word_t           out_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [kbh_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [kbh_pkg::HASH_W-1:0]   dvd_reg, dvd_next;
    logic [kbh_pkg::HASH_W-1:0]   hash_reg, hash_next;
    logic [kbh_pkg::BUCKET_W-1:0] rem_reg, rem_next;
    logic [kbh_pkg::BUCKET_W-1:0] div_reg, div_next;
    logic [kbh_pkg::BUCKET_W-1:0] bcount_reg;
    logic                         ovalid_reg, ovalid_next;
    kbh_pkg::out_word_t           out_reg, out_next;
    logic [kbh_pkg::BUCKET_W:0]   trial;
    logic [kbh_pkg::BUCKET_W:0]   trial_diff;
    logic [kbh_pkg::BUCKET_W-1:0] rem_step;
    logic                         load_out;

    // bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= kbh_pkg::BUCKET_RESET;
        else if (cfg_wr_en)
            bcount_reg <= cfg_wr_data;
    end

    // one restoring remainder step
    assign trial      = {rem_reg, dvd_reg[kbh_pkg::HASH_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign rem_step   = (trial >= {1'b0, div_reg}) ? trial_diff[kbh_pkg::BUCKET_W-1:0]
                                                   : trial[kbh_pkg::BUCKET_W-1:0];

    assign q_rd_en  = (state_reg == ST_IDLE) && !q_status.empty;
    assign load_out = (state_reg == ST_HOLD) && (!ovalid_reg || pop);
    assign empty    = !ovalid_reg;
    assign out_word = out_reg;

    // remainder sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    hash_next  = q_rd_data;
                    dvd_next   = q_rd_data;
                    div_next   = bcount_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[kbh_pkg::HASH_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == '1)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        if (load_out)
        begin
            out_next.bucket    = (div_reg == '0) ? '0 : rem_reg;
            out_next.hash_word = hash_reg;
            ovalid_next        = 1'b1;
        end
        else if (pop)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        out_reg  <= out_next;
    end

    // finished remainder is below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("remainder not reduced below bucket count");

    // the step loop runs to its end
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step_reg != '1) |=> (state_reg == ST_RUN))
        else $error("remainder loop left early");

endmodule

// File: design/key_bucket_hash.sv
// Key hash and bucket index. Key bytes are pushed one word per cycle while full is low, first
// byte first, with last_byte on the final word (no_byte with last_byte ends the key without
// a byte; an empty key gives hash 0 and bucket 0). The front folds each byte in the cycle it
// is taken; on the last word the 32-bit hash enters a two-entry queue. The back pulls one
// hash at a time and reduces it modulo bucket_count with a one-bit-per-cycle remainder
// loop. full rises while the queue holds two hashes. bucket_count is sampled when a hash
// leaves the queue; a bucket count of zero gives bucket 0.
module key_bucket_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  kbh_pkg::in_word_t            in_word,
    output logic                         empty,
    input  logic                         pop,
    output kbh_pkg::out_word_t           out_word,
    input  logic                         cfg_wr_en,
    input  logic [kbh_pkg::BUCKET_W-1:0] cfg_wr_data
);

    kbh_pkg::qstat_t            q_status;
    logic                       q_wr_en;
    logic [kbh_pkg::HASH_W-1:0] q_wr_data;
    logic                       q_rd_en;
    logic [kbh_pkg::HASH_W-1:0] q_rd_data;

    // byte folding front
    kbh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .q_status  (q_status),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    // hash queue
    kbh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // bucket reduction back
    kbh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .q_rd_data   (q_rd_data),
        .q_rd_en     (q_rd_en),
        .empty       (empty),
        .pop         (pop),
        .out_word    (out_word)
    );

endmodule

// File: test/tb_key_bucket_hash.sv
module tb_key_bucket_hash;

    // one row of the directed table
    typedef struct packed {
        kbh_pkg::in_word_t  w;
        logic               typed;
        kbh_pkg::out_word_t want;
    } stim_row_t;

    localparam int N_DIRECTED   = 24;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 285;
    localparam int MAX_GAP      = 16;
    localparam int SETTLE_CYC   = 40;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int LONG_HOLD_AT = 25;
    localparam int LONG_HOLD    = 400;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    kbh_pkg::in_word_t            in_word;
    logic                         empty;
    logic                         pop;
    kbh_pkg::out_word_t           out_word;
    logic                         cfg_wr_en;
    logic [kbh_pkg::BUCKET_W-1:0] cfg_wr_data;

    // hash predictor state
    logic [kbh_pkg::HASH_W-1:0]   fold_acc;
    logic [kbh_pkg::PEND_W-1:0]   tail_bytes;
    logic [kbh_pkg::PCNT_W-1:0]   tail_cnt;
    logic                         has_folded;
    logic [kbh_pkg::BUCKET_W-1:0] n_buckets;

    kbh_pkg::out_word_t pending_results[$];
    int                 err_cnt     = 0;
    int                 words_taken = 0;
    bit                 snd_burst   = 1'b0;
    bit                 rcv_burst   = 1'b0;

    key_bucket_hash uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_word     (in_word),
        .empty       (empty),
        .pop         (pop),
        .out_word    (out_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // fold one key word; returns 1 when the key ends, with the hash and bucket
    function automatic bit fold_word(input kbh_pkg::in_word_t w,
                                     output kbh_pkg::out_word_t r);
        logic [kbh_pkg::HASH_W-1:0] h;
        logic [kbh_pkg::HASH_W-1:0] grp;
        r = '0;
        if (!w.no_byte)
        begin
            if (tail_cnt == kbh_pkg::PCNT_W'(kbh_pkg::GROUP_BYTES - 1))
            begin
                fold_acc   = (fold_acc >> 1) ^ {tail_bytes, w.key_byte};
                has_folded = 1'b1;
                tail_bytes = '0;
                tail_cnt   = '0;
            end
            else
            begin
                tail_bytes = {tail_bytes[kbh_pkg::PEND_W-kbh_pkg::BYTE_W-1:0], w.key_byte};
                tail_cnt   = tail_cnt + 1'b1;
            end
        end
        if (!w.last_byte)
            return 1'b0;
        // short key, partial trailing group, or whole groups only
        if (!has_folded)
            h = kbh_pkg::HASH_W'(tail_bytes);
        else if (tail_cnt != '0)
        begin
            grp = kbh_pkg::HASH_W'(tail_bytes)
                  << (kbh_pkg::BYTE_W * (kbh_pkg::GROUP_BYTES - int'(tail_cnt)));
            h   = (fold_acc >> 1) ^ grp;
        end
        else
            h = fold_acc;
        r.hash_word = h;
        r.bucket    = (n_buckets == '0) ? '0 : kbh_pkg::BUCKET_W'(h % n_buckets);
        fold_acc   = '0;
        tail_bytes = '0;
        tail_cnt   = '0;
        has_folded = 1'b0;
        return 1'b1;
    endfunction

    // offer one word after a random gap; predict once it is taken
    task automatic send_word(input kbh_pkg::in_word_t w, input logic typed,
                             input kbh_pkg::out_word_t want);
        kbh_pkg::out_word_t r;
        int                 gap;
        gap = snd_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        if (fold_word(w, r))
            pending_results.push_back(typed ? want : r);
    endtask

    // random key of len bytes, with stray no-byte words mixed in
    task automatic send_key(input int len, input bit end_empty);
        kbh_pkg::in_word_t w;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                w = {8'($urandom_range(0, 255)), 1'b0, 1'b1};
                send_word(w, 1'b0, '0);
            end
            w.key_byte  = 8'($urandom_range(0, 255));
            w.last_byte = (i == len - 1) && !end_empty;
            w.no_byte   = 1'b0;
            send_word(w, 1'b0, '0);
        end
        if (end_empty)
        begin
            w = {8'($urandom_range(0, 255)), 1'b1, 1'b1};
            send_word(w, 1'b0, '0);
        end
    endtask

    // hold off until every expected word is back or the drain limit runs out, then let the back stage settle
    task automatic wait_drained();
        int c;
        c = 0;
        while (pending_results.size() != 0 && c < DRAIN_LIMIT)
        begin
            @(posedge clk);
            c++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // bucket count write
    task automatic load_buckets(input logic [kbh_pkg::BUCKET_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        n_buckets = v;
    endtask

    // compare one taken word against the oldest expectation
    task automatic check_result(input kbh_pkg::out_word_t got);
        kbh_pkg::out_word_t want;
        if (pending_results.size() == 0)
        begin
            $error("result word with nothing expected: bucket %0d hash_word %h",
                   got.bucket, got.hash_word);
            err_cnt++;
            return;
        end
        want = pending_results.pop_front();
        if (got.bucket !== want.bucket)
        begin
            $error("bucket: expected %0d, actual %0d", want.bucket, got.bucket);
            err_cnt++;
        end
        if (got.hash_word !== want.hash_word)
        begin
            $error("hash_word: expected %h, actual %h", want.hash_word, got.hash_word);
            err_cnt++;
        end
    endtask

    // result side: random stalls, one long hold to back up the block
    initial
    begin : result_side
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (words_taken == LONG_HOLD_AT)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = rcv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            check_result(out_word);
            words_taken++;
            if ($urandom_range(0, 7) == 0)
                rcv_burst = !rcv_burst;
        end
    end

    // main stimulus
    initial
    begin : key_side
        stim_row_t                    dir_rows [N_DIRECTED];
        logic [kbh_pkg::BUCKET_W-1:0] phase_counts [N_PHASES];
        int                           taken;
        int                           len;
        int                           pick;
        bit                           tail_none;

        rst_n       <= 1'b0;
        push        <= 1'b0;
        in_word     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        fold_acc   = '0;
        tail_bytes = '0;
        tail_cnt   = '0;
        has_folded = 1'b0;
        n_buckets  = kbh_pkg::BUCKET_RESET;

        // key byte, last, no byte | typed, bucket, hash
        dir_rows = '{
            {8'h00, 1'b1, 1'b1, 1'b1, 16'h0000, 32'h0000_0000},  // empty key
            {8'hff, 1'b1, 1'b0, 1'b1, 16'h00ff, 32'h0000_00ff},
            {8'h00, 1'b1, 1'b0, 1'b1, 16'h0000, 32'h0000_0000},
            {8'h12, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},  // three-byte key
            {8'h34, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h56, 1'b1, 1'b0, 1'b1, 16'h0056, 32'h0012_3456},
            {8'haa, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000},  // ignored word
            {8'hff, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},  // one full group
            {8'hff, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'hff, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'hff, 1'b1, 1'b0, 1'b1, 16'h00ff, 32'hffff_ffff},
            {8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},  // group plus one byte
            {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h7f, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},  // ended by no byte
            {8'h02, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h00, 1'b1, 1'b1, 1'b1, 16'h0002, 32'h0000_0102},
            {8'hde, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},  // full group, no byte end
            {8'had, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'hbe, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'hef, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
            {8'h55, 1'b1, 1'b1, 1'b0, 16'h0000, 32'h0000_0000}
        };
        phase_counts = '{16'd1, 16'hffff, 16'd0, 16'($urandom_range(2, 65534)),
                         16'd7, kbh_pkg::BUCKET_RESET};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset bucket count
        foreach (dir_rows[i])
        begin
            snd_burst = ($urandom_range(0, 2) == 0);
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        end
        push <= 1'b0;

        // random keys, one bucket count per phase
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_drained();
            load_buckets(phase_counts[ph]);
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                snd_burst = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    len = 0;
                else if (pick < 3)
                    len = $urandom_range(13, 24);
                else
                    len = $urandom_range(1, 12);
                tail_none = (len == 0) || ($urandom_range(0, 5) == 0);
                send_key(len, tail_none);
                taken += len + int'(tail_none);
            end
            push <= 1'b0;
        end

        wait_drained();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result words never arrived", pending_results.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #6000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
design/kbh_pkg.sv
design/kbh_front.sv
design/kbh_queue.sv
design/kbh_back.sv
design/key_bucket_hash.sv
test/tb_key_bucket_hash.sv
